/* design/peer_backoff_blacklist_unit_macros.svh */
// assertion macros used by the lockout table checker
// no dependencies; included by bare file name
`ifndef PEER_BACKOFF_BLACKLIST_UNIT_MACROS_SVH
`define PEER_BACKOFF_BLACKLIST_UNIT_MACROS_SVH

// property checked only once reset has been released
`define PBB_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every rising clock edge, reset included
`define PBB_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/pbb_pkg.sv */
// shared types, constants and helpers for the peer lockout table
// no dependencies; used by every module of the block
package pbb_pkg;

    localparam int ENTRIES   = 8;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ADDR_W    = 48;
    localparam int TICK_W    = 32;
    localparam int LVL_W     = 5;
    localparam int LVL_MAX   = 31;
    localparam int SHIFT_W   = TICK_W + LVL_MAX;
    localparam int IN_W      = 80;
    localparam int OUT_W     = 40;
    localparam int REQ_W     = 2;
    localparam int DATA_W    = 32;
    localparam int PADDR_W   = 4;
    localparam int REG_IDX_W = 2;

    localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(LVL_MAX);

    localparam logic [REQ_W-1:0] REQ_ELAPSED = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FAIL    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY   = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_MIN_WAIT = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAX_WAIT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_PERIOD   = 2'd2;

    localparam logic [TICK_W-1:0] MIN_WAIT_RST = 32'd2000;
    localparam logic [TICK_W-1:0] MAX_WAIT_RST = 32'd64000;
    localparam logic [TICK_W-1:0] PERIOD_RST   = 32'd10000;

    typedef struct packed {
        logic [TICK_W-1:0] min_wait;
        logic [TICK_W-1:0] max_wait;
        logic [TICK_W-1:0] period;
    } cfg_t;

    typedef struct packed {
        logic              is_fail;
        logic              is_query;
        logic [ADDR_W-1:0] addr;
        logic [TICK_W-1:0] ticks;
    } req_t;

    typedef struct packed {
        logic              v;
        logic [TICK_W-1:0] a;
    } wake_t;

    typedef struct packed {
        logic             valid;
        wake_t            wake;
        logic             matched;
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
        logic             locked;
    } token_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } alloc_t;

    // fold a candidate wake-up time into the running minimum
    function automatic wake_t offer(wake_t cur, wake_t cand);
        wake_t r;
        r = cur;
        if (cand.v && (!cur.v || (cand.a < cur.a)))
        begin
            r.a = cand.a;
        end
        r.v = cur.v | cand.v;
        return r;
    endfunction

endpackage

/* design/peer_backoff_blacklist_unit.sv */
// top level of the peer lockout table: stream ports, sequencer, cell chain
// depends on pbb_pkg, pbb_cfg and pbb_cell
//
// The table is a chain of ENTRIES cells, one peer each. An accepted transaction sends an
// ageing pulse down the chain one cell per clock, and in the clock after it a lookup token
// that gathers the minimum wake-up time, the lockout flag of a query and the match and
// highest free slot of a failure; a new peer is written into its slot as the token leaves
// the last cell. The result is registered, then moved into the output register once that
// is free, and only then is the next input taken, so the chain holds one transaction at
// a time, paced by the ripple of the token through it. The output register holds a result
// while the next transaction is accepted. Reset empties the table at once.
module peer_backoff_blacklist_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    // s_tdata: peer_address [47:0], ticks_elapsed [79:48]
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [pbb_pkg::IN_W-1:0]     s_tdata,
    // s_tuser: req_type [1:0]
    input  logic [pbb_pkg::REQ_W-1:0]    s_tuser,
    // m_tdata: locked_out [0], wake_valid [1], wake_after [33:2], table_full [34], zero above
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [pbb_pkg::OUT_W-1:0]    m_tdata,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pbb_pkg::PADDR_W-1:0]  paddr,
    input  logic [pbb_pkg::DATA_W-1:0]   pwdata,
    output logic [pbb_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    typedef enum logic [1:0] {ST_IDLE, ST_BUSY, ST_DONE} state_t;

    state_t                          state_reg;
    logic                            start_reg;
    logic                            start_d_reg;
    pbb_pkg::req_t                   req_reg;
    pbb_pkg::req_t                   req_in;
    logic [pbb_pkg::OUT_W-1:0]       res_reg;
    logic [pbb_pkg::OUT_W-1:0]       res_next;
    logic                            m_tvalid_reg;
    logic [pbb_pkg::OUT_W-1:0]       m_tdata_reg;

    pbb_pkg::cfg_t                   cfg;
    pbb_pkg::alloc_t                 alloc;
    logic                            age_chain [0:pbb_pkg::ENTRIES-1];
    pbb_pkg::token_t                 tok_chain [0:pbb_pkg::ENTRIES];
    pbb_pkg::token_t                 tok_last;
    pbb_pkg::wake_t                  new_offer;
    pbb_pkg::wake_t                  wake_fin;
    logic                            full;

    assign pready   = 1'b1;
    assign s_tready = (state_reg == ST_IDLE);

    assign req_in.is_fail  = (s_tuser == pbb_pkg::REQ_FAIL);
    assign req_in.is_query = (s_tuser == pbb_pkg::REQ_QUERY);
    assign req_in.addr     = s_tdata[pbb_pkg::ADDR_W-1:0];
    assign req_in.ticks    = s_tdata[pbb_pkg::ADDR_W +: pbb_pkg::TICK_W];

    pbb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign age_chain[0] = start_reg;

    always_comb
    begin
        tok_chain[0]       = '0;
        tok_chain[0].valid = start_d_reg;
    end

    for (genvar i = 0; i < pbb_pkg::ENTRIES; i++)
    begin : g_cell
        if (i == pbb_pkg::ENTRIES - 1)
        begin : g_tail
            pbb_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cell_idx (pbb_pkg::IDX_W'(i)),
                .cfg      (cfg),
                .req      (req_reg),
                .alloc    (alloc),
                .age_in   (age_chain[i]),
                .age_out  (),
                .tok_in   (tok_chain[i]),
                .tok_out  (tok_chain[i+1])
            );
        end
        else
        begin : g_body
            pbb_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cell_idx (pbb_pkg::IDX_W'(i)),
                .cfg      (cfg),
                .req      (req_reg),
                .alloc    (alloc),
                .age_in   (age_chain[i]),
                .age_out  (age_chain[i+1]),
                .tok_in   (tok_chain[i]),
                .tok_out  (tok_chain[i+1])
            );
        end
    end

    assign tok_last = tok_chain[pbb_pkg::ENTRIES];

    // a new peer takes the highest free slot once no entry matched
    assign alloc.en  = (state_reg == ST_BUSY) && tok_last.valid && req_reg.is_fail
                       && !tok_last.matched && tok_last.free_found;
    assign alloc.idx = tok_last.free_idx;

    assign new_offer.v = 1'b1;
    assign new_offer.a = cfg.min_wait;
    assign wake_fin    = alloc.en ? pbb_pkg::offer(tok_last.wake, new_offer) : tok_last.wake;
    assign full        = req_reg.is_fail && !tok_last.matched && !tok_last.free_found;

    assign res_next = {{(pbb_pkg::OUT_W - pbb_pkg::TICK_W - 3){1'b0}},
                       full,
                       wake_fin.v ? wake_fin.a : {pbb_pkg::TICK_W{1'b0}},
                       wake_fin.v,
                       tok_last.locked};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            start_reg    <= 1'b0;
            start_d_reg  <= 1'b0;
            req_reg      <= '0;
            res_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            start_reg   <= 1'b0;
            start_d_reg <= start_reg;
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        req_reg   <= req_in;
                        start_reg <= 1'b1;
                        state_reg <= ST_BUSY;
                    end
                end
                ST_BUSY:
                begin
                    if (tok_last.valid)
                    begin
                        res_reg   <= res_next;
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= res_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* design/pbb_cfg.sv */
// configuration register bank behind the apb-style port
// depends on pbb_pkg
module pbb_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pbb_pkg::PADDR_W-1:0]  paddr,
    input  logic [pbb_pkg::DATA_W-1:0]   pwdata,
    output logic [pbb_pkg::DATA_W-1:0]   prdata,
    output pbb_pkg::cfg_t                cfg
);

    pbb_pkg::cfg_t                   cfg_reg;
    pbb_pkg::cfg_t                   cfg_next;
    logic [pbb_pkg::REG_IDX_W-1:0]   reg_idx;
    logic                            wr_en;

    assign reg_idx = paddr[pbb_pkg::PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                pbb_pkg::REG_MIN_WAIT: cfg_next.min_wait = pwdata;
                pbb_pkg::REG_MAX_WAIT: cfg_next.max_wait = pwdata;
                pbb_pkg::REG_PERIOD:   cfg_next.period   = pwdata;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            pbb_pkg::REG_MIN_WAIT: prdata = cfg_reg.min_wait;
            pbb_pkg::REG_MAX_WAIT: prdata = cfg_reg.max_wait;
            pbb_pkg::REG_PERIOD:   prdata = cfg_reg.period;
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_wait <= pbb_pkg::MIN_WAIT_RST;
            cfg_reg.max_wait <= pbb_pkg::MAX_WAIT_RST;
            cfg_reg.period   <= pbb_pkg::PERIOD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* design/pbb_cell.sv */
// one table entry: ages on the passing pulse, then renews or reports on the token
// depends on pbb_pkg
module pbb_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [pbb_pkg::IDX_W-1:0]  cell_idx,
    input  pbb_pkg::cfg_t              cfg,
    input  pbb_pkg::req_t              req,
    input  pbb_pkg::alloc_t            alloc,
    input  logic                       age_in,
    output logic                       age_out,
    input  pbb_pkg::token_t            tok_in,
    output pbb_pkg::token_t            tok_out
);

    logic                                valid_reg, valid_next;
    logic                                active_reg, active_next;
    logic [pbb_pkg::LVL_W-1:0]           lvl_reg, lvl_next;
    logic [pbb_pkg::TICK_W-1:0]          pen_reg, pen_next;
    logic [pbb_pkg::TICK_W-1:0]          sum_reg, sum_next;
    logic [pbb_pkg::ADDR_W-1:0]          addr_reg, addr_next;
    pbb_pkg::wake_t                      offer_reg, offer_next;
    logic                                age_out_reg;
    pbb_pkg::token_t                     tok_out_reg, tok_out_next;

    // ageing results
    logic [pbb_pkg::TICK_W-1:0]          ticks;
    logic [pbb_pkg::TICK_W:0]            sum_ext;
    logic [pbb_pkg::TICK_W-1:0]          sum_sat;
    logic                                a_valid, a_active;
    logic [pbb_pkg::LVL_W-1:0]           a_lvl;
    logic [pbb_pkg::TICK_W-1:0]          a_pen, a_sum;
    pbb_pkg::wake_t                      a_offer;

    // renewal results
    logic                                addr_hit;
    logic [pbb_pkg::SHIFT_W-1:0]         shifted;
    logic [pbb_pkg::SHIFT_W-1:0]         max_ext;
    logic                                raise;
    logic [pbb_pkg::SHIFT_W:0]           len_ext;
    logic [pbb_pkg::TICK_W-1:0]          len;
    logic [pbb_pkg::LVL_W-1:0]           new_lvl;
    logic                                renew;
    pbb_pkg::wake_t                      ren_offer;

    assign ticks   = req.is_query ? '0 : req.ticks;
    assign sum_ext = {1'b0, sum_reg} + {1'b0, ticks};
    assign sum_sat = sum_ext[pbb_pkg::TICK_W] ? '1 : sum_ext[pbb_pkg::TICK_W-1:0];

    always_comb
    begin
        a_valid   = valid_reg;
        a_active  = active_reg;
        a_lvl     = lvl_reg;
        a_pen     = pen_reg;
        a_sum     = sum_reg;
        a_offer.v = 1'b0;
        a_offer.a = '0;
        if (valid_reg)
        begin
            if (active_reg)
            begin
                if (pen_reg > ticks)
                begin
                    a_pen     = pen_reg - ticks;
                    a_offer.v = 1'b1;
                    a_offer.a = pen_reg - ticks;
                end
                else
                begin
                    a_active = 1'b0;
                    if (lvl_reg == '0)
                    begin
                        a_valid = 1'b0;
                    end
                    else
                    begin
                        a_offer.v = 1'b1;
                        a_offer.a = cfg.period;
                    end
                end
            end
            else if (lvl_reg == '0)
            begin
                a_valid = 1'b0;
            end
            else
            begin
                if (sum_sat >= cfg.period)
                begin
                    a_lvl = lvl_reg - 1'b1;
                    a_sum = sum_sat - cfg.period;
                end
                else
                begin
                    a_sum = sum_sat;
                end
                // a backlog still at or above the period asks for an immediate wake-up
                a_offer.v = 1'b1;
                a_offer.a = (a_sum < cfg.period) ? (cfg.period - a_sum) : '0;
            end
        end
    end

    // lockout length of the raised level, saturating at 32 bits
    assign addr_hit = (addr_reg == req.addr);
    assign shifted  = {{pbb_pkg::LVL_MAX{1'b0}}, cfg.min_wait} << lvl_reg;
    assign max_ext  = {{pbb_pkg::LVL_MAX{1'b0}}, cfg.max_wait};
    assign raise    = (lvl_reg != pbb_pkg::LVL_TOP) && (shifted < max_ext);
    assign len_ext  = raise ? {shifted, 1'b0} : {1'b0, shifted};
    assign len      = (|len_ext[pbb_pkg::SHIFT_W:pbb_pkg::TICK_W]) ? '1
                                                               : len_ext[pbb_pkg::TICK_W-1:0];
    assign new_lvl  = raise ? (lvl_reg + 1'b1) : lvl_reg;
    assign renew    = tok_in.valid && req.is_fail && valid_reg && addr_hit;

    assign ren_offer.v = 1'b1;
    assign ren_offer.a = len;

    always_comb
    begin
        tok_out_next      = tok_in;
        tok_out_next.wake = pbb_pkg::offer(tok_in.wake, offer_reg);
        if (req.is_query && valid_reg && active_reg && addr_hit)
        begin
            tok_out_next.locked = 1'b1;
        end
        if (req.is_fail)
        begin
            if (valid_reg && addr_hit)
            begin
                tok_out_next.matched = 1'b1;
                tok_out_next.wake    = pbb_pkg::offer(tok_out_next.wake, ren_offer);
            end
            else if (!valid_reg)
            begin
                // later cells overwrite, so the highest free slot wins
                tok_out_next.free_found = 1'b1;
                tok_out_next.free_idx   = cell_idx;
            end
        end
    end

    always_comb
    begin
        valid_next  = valid_reg;
        active_next = active_reg;
        lvl_next    = lvl_reg;
        pen_next    = pen_reg;
        sum_next    = sum_reg;
        addr_next   = addr_reg;
        offer_next  = age_in ? a_offer : offer_reg;
        if (age_in && !req.is_query)
        begin
            valid_next  = a_valid;
            active_next = a_active;
            lvl_next    = a_lvl;
            pen_next    = a_pen;
            sum_next    = a_sum;
        end
        if (renew)
        begin
            lvl_next    = new_lvl;
            sum_next    = '0;
            pen_next    = len;
            active_next = 1'b1;
        end
        if (alloc.en && (alloc.idx == cell_idx))
        begin
            addr_next   = req.addr;
            lvl_next    = '0;
            sum_next    = '0;
            pen_next    = cfg.min_wait;
            active_next = 1'b1;
            valid_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            active_reg  <= 1'b0;
            age_out_reg <= 1'b0;
            tok_out_reg <= '0;
        end
        else
        begin
            valid_reg   <= valid_next;
            active_reg  <= active_next;
            age_out_reg <= age_in;
            tok_out_reg <= tok_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg   <= lvl_next;
        pen_reg   <= pen_next;
        sum_reg   <= sum_next;
        addr_reg  <= addr_next;
        offer_reg <= offer_next;
    end

    assign age_out = age_out_reg;
    assign tok_out = tok_out_reg;

endmodule

/* design/pbb_checker.sv */
// port-level checks for the peer lockout table, bound to the top level
// depends on pbb_pkg and peer_backoff_blacklist_unit_macros.svh
`include "peer_backoff_blacklist_unit_macros.svh"

module pbb_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [pbb_pkg::OUT_W-1:0]  m_tdata,
    input logic                       pready
);

    `PBB_ASSERT_ALWAYS(a_pready_high, clk, pready, "pready must stay high")

    // one transaction in the chain at a time
    `PBB_ASSERT_RST(a_one_in_flight, clk, rst_n, s_tvalid && s_tready |=> !s_tready, "input taken while busy")

    // a result never appears the cycle straight after an input transaction
    `PBB_ASSERT_RST(a_no_instant_result, clk, rst_n, s_tvalid && s_tready |=> !$rose(m_tvalid), "result too early")

    `PBB_ASSERT_RST(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

    `PBB_ASSERT_RST(a_wake_zero, clk, rst_n, m_tvalid && !m_tdata[1] |-> m_tdata[33:2] == 32'd0, "wake time without wake flag")

endmodule

bind peer_backoff_blacklist_unit pbb_checker u_pbb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);

/* tb/testbench.sv */
// self-checking testbench for peer_backoff_blacklist_unit: directed table, then random phases
// depends on pbb_pkg and the peer_backoff_blacklist_unit rtl; holds its own lockout table model
module testbench;
    import pbb_pkg::*;

    localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;
    localparam int DIR_ROWS_N = 21;
    localparam int POOL_N = 10;
    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 292;

    typedef struct packed {
        logic              locked;
        logic              wake_v;
        logic [TICK_W-1:0] wake_after;
        logic              full;
    } lockout_result_t;

    typedef struct packed {
        logic [REQ_W-1:0]  kind;
        logic [ADDR_W-1:0] addr;
        logic [TICK_W-1:0] ticks;
        logic              typed;
        lockout_result_t   want;
    } stim_row_t;

    // default register values throughout; typed results only where obvious
    localparam stim_row_t DIR_ROWS [DIR_ROWS_N] = '{
        '{REQ_QUERY,   48'h0000_0000_0000, 32'd0,          1'b1, '{1'b0, 1'b0, 32'd0, 1'b0}},
        '{REQ_ELAPSED, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF,  1'b1, '{1'b0, 1'b0, 32'd0, 1'b0}},
        '{REQ_FAIL,    48'hFFFF_FFFF_FFFF, 32'd0,          1'b1, '{1'b0, 1'b1, 32'd2000, 1'b0}},
        '{REQ_QUERY,   48'hFFFF_FFFF_FFFF, 32'd0,          1'b1, '{1'b1, 1'b1, 32'd2000, 1'b0}},
        '{REQ_QUERY,   48'h0000_0000_0000, 32'hFFFF_FFFF,  1'b1, '{1'b0, 1'b1, 32'd2000, 1'b0}},
        '{REQ_FAIL,    48'hFFFF_FFFF_FFFF, 32'd500,        1'b0, '0},
        '{REQ_FAIL,    48'h0000_0000_0000, 32'd0,          1'b0, '0},
        '{REQ_FAIL,    48'h5555_5555_5555, 32'd1,          1'b0, '0},
        '{REQ_FAIL,    48'hAAAA_AAAA_AAAA, 32'd2,          1'b0, '0},
        '{REQ_FAIL,    48'h0000_0000_0001, 32'd3,          1'b0, '0},
        '{REQ_FAIL,    48'h8000_0000_0000, 32'd4,          1'b0, '0},
        '{REQ_FAIL,    48'h1234_5678_9ABC, 32'd5,          1'b0, '0},
        '{REQ_FAIL,    48'h0F0F_0F0F_0F0F, 32'd6,          1'b0, '0},
        '{REQ_FAIL,    48'h7654_3210_FEDC, 32'd7,          1'b0, '0},
        '{REQ_SPARE,   48'h0000_0000_0000, 32'd1000,       1'b0, '0},
        '{REQ_QUERY,   48'h5555_5555_5555, 32'd0,          1'b0, '0},
        '{REQ_ELAPSED, 48'h0000_0000_0000, 32'hFFFF_FFFF,  1'b0, '0},
        '{REQ_QUERY,   48'hFFFF_FFFF_FFFF, 32'd0,          1'b0, '0},
        '{REQ_ELAPSED, 48'h0000_0000_0000, 32'd9999,       1'b0, '0},
        '{REQ_ELAPSED, 48'h0000_0000_0000, 32'd1,          1'b0, '0},
        '{REQ_ELAPSED, 48'h0000_0000_0000, 32'd0,          1'b1, '{1'b0, 1'b0, 32'd0, 1'b0}}
    };

    // min wait, max wait, reward period per phase; the last phase is drawn at random
    localparam logic [3*TICK_W-1:0] PHASE_CFG [PHASES-1] = '{
        {MIN_WAIT_RST, MAX_WAIT_RST, PERIOD_RST},
        {32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
        {32'h4000_0000, 32'hFFFF_FFFF, 32'd1},
        {32'd0, 32'd1, 32'd0},
        {32'hFFFF_FFFF, 32'd1, 32'd1}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [IN_W-1:0] s_tdata;
    logic [REQ_W-1:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_W-1:0] m_tdata;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    // model copy of the configuration and of the peer table
    logic [TICK_W-1:0] cur_min_wait;
    logic [TICK_W-1:0] cur_max_wait;
    logic [TICK_W-1:0] cur_period;
    logic [ADDR_W-1:0] peer_mac [ENTRIES];
    logic              peer_valid [ENTRIES];
    logic              peer_active [ENTRIES];
    logic [LVL_W-1:0]  peer_level [ENTRIES];
    logic [TICK_W-1:0] peer_penalty [ENTRIES];
    logic [TICK_W-1:0] peer_reward [ENTRIES];

    lockout_result_t pending_results [$];
    logic [ADDR_W-1:0] peer_pool [POOL_N];
    bit gaps_on;
    int fail_count;
    int n_items;
    int n_results;
    int n_locked;
    int n_full;

    peer_backoff_blacklist_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void fold_wake(inout logic wv, inout logic [TICK_W-1:0] wa,
                                      input logic [TICK_W-1:0] t);
        if (!wv || t < wa)
        begin
            wa = t;
        end
        wv = 1'b1;
    endfunction

    function automatic logic [TICK_W-1:0] lockout_ticks(logic [LVL_W-1:0] lvl);
        logic [63:0] p;
        p = 64'(cur_min_wait) << lvl;
        return (p > 64'hFFFF_FFFF) ? '1 : p[TICK_W-1:0];
    endfunction

    function automatic logic [LVL_W-1:0] bumped_level(logic [LVL_W-1:0] lvl);
        logic [63:0] p;
        p = 64'(cur_min_wait) << lvl;
        if (lvl >= LVL_TOP || p >= 64'(cur_max_wait))
        begin
            return lvl;
        end
        return lvl + 1'b1;
    endfunction

    function automatic void age_peers(input logic [TICK_W-1:0] ticks, input bit commit,
                                      inout logic wv, inout logic [TICK_W-1:0] wa);
        logic vld;
        logic act;
        logic [LVL_W-1:0] lvl;
        logic [TICK_W-1:0] pen;
        logic [TICK_W-1:0] sum;
        logic [TICK_W:0] grown;
        for (int i = 0; i < ENTRIES; i++)
        begin
            vld = peer_valid[i];
            act = peer_active[i];
            lvl = peer_level[i];
            pen = peer_penalty[i];
            sum = peer_reward[i];
            if (vld)
            begin
                if (act)
                begin
                    if (pen > ticks)
                    begin
                        pen = pen - ticks;
                        fold_wake(wv, wa, pen);
                    end
                    else
                    begin
                        act = 1'b0;
                        if (lvl == '0)
                            vld = 1'b0;
                        else
                            fold_wake(wv, wa, cur_period);
                    end
                end
                else if (lvl == '0)
                begin
                    vld = 1'b0;
                end
                else
                begin
                    grown = {1'b0, sum} + {1'b0, ticks};
                    sum = grown[TICK_W] ? '1 : grown[TICK_W-1:0];
                    if (sum >= cur_period)
                    begin
                        lvl = lvl - 1'b1;
                        sum = sum - cur_period;
                    end
                    // reward backlog leaves a wake time of zero
                    fold_wake(wv, wa, (sum < cur_period) ? cur_period - sum : '0);
                end
                if (commit)
                begin
                    peer_valid[i] = vld;
                    peer_active[i] = act;
                    peer_level[i] = lvl;
                    peer_penalty[i] = pen;
                    peer_reward[i] = sum;
                end
            end
        end
    endfunction

    function automatic lockout_result_t predict_lockout(logic [REQ_W-1:0] kind,
                                                        logic [ADDR_W-1:0] addr,
                                                        logic [TICK_W-1:0] ticks);
        lockout_result_t r;
        logic wv;
        logic [TICK_W-1:0] wa;
        bit matched;
        int free_idx;
        r = '0;
        wv = 1'b0;
        wa = '0;
        matched = 1'b0;
        free_idx = -1;
        if (kind == REQ_QUERY)
        begin
            age_peers('0, 1'b0, wv, wa);
            for (int i = 0; i < ENTRIES; i++)
                if (peer_valid[i] && peer_active[i] && peer_mac[i] == addr)
                    r.locked = 1'b1;
        end
        else
        begin
            age_peers(ticks, 1'b1, wv, wa);
            if (kind == REQ_FAIL)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (!peer_valid[i])
                    begin
                        free_idx = i;
                    end
                    else if (peer_mac[i] == addr)
                    begin
                        peer_level[i] = bumped_level(peer_level[i]);
                        peer_reward[i] = '0;
                        peer_penalty[i] = lockout_ticks(peer_level[i]);
                        peer_active[i] = 1'b1;
                        fold_wake(wv, wa, peer_penalty[i]);
                        matched = 1'b1;
                    end
                end
                // a new peer takes the highest free slot
                if (!matched && free_idx >= 0)
                begin
                    peer_mac[free_idx] = addr;
                    peer_level[free_idx] = '0;
                    peer_reward[free_idx] = '0;
                    peer_penalty[free_idx] = lockout_ticks('0);
                    peer_active[free_idx] = 1'b1;
                    peer_valid[free_idx] = 1'b1;
                    fold_wake(wv, wa, peer_penalty[free_idx]);
                end
                else if (!matched)
                begin
                    r.full = 1'b1;
                end
            end
        end
        r.wake_v = wv;
        r.wake_after = wv ? wa : '0;
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [TICK_W-1:0] pick_ticks();
        logic [TICK_W-1:0] lim;
        int k;
        case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            2: return $urandom;
            3, 4, 5, 6, 7: return $urandom_range(0, 7);
            default:
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    lim = cur_period;
                end
                else
                begin
                    k = $urandom_range(0, 5);
                    lim = (cur_min_wait > (32'hFFFF_FFFF >> k)) ? '1 : cur_min_wait << k;
                end
                if (lim == '0)
                    lim = 32'd16;
                return $urandom_range(0, lim);
            end
        endcase
    endfunction

    // called at a falling edge; leaves tvalid high after the transaction
    task automatic offer_item(logic [REQ_W-1:0] kind, logic [ADDR_W-1:0] addr,
                              logic [TICK_W-1:0] ticks, logic typed, lockout_result_t want);
        lockout_result_t predicted;
        while (gaps_on && $urandom_range(0, 99) < 27)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {ticks, addr};
        s_tuser <= kind;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = predict_lockout(kind, addr, ticks);
        pending_results.push_back(typed ? want : predicted);
        n_items++;
        @(negedge clk);
    endtask

    // wait for every result, then let the token chain run dry
    task automatic drain_results();
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);
    endtask

    task automatic set_register(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== value)
        begin
            if (fail_count < 10)
                $display("register %0d read back %h, wrote %h", idx, prdata, value);
            fail_count++;
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        case (idx)
            REG_MIN_WAIT: cur_min_wait = value;
            REG_MAX_WAIT: cur_max_wait = value;
            REG_PERIOD:   cur_period = value;
            default: ;
        endcase
    endtask

    always @(negedge clk)
        m_tready <= !(gaps_on && $urandom_range(0, 99) < 27);

    always @(posedge clk)
    begin : result_check
        lockout_result_t got;
        lockout_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.locked = m_tdata[0];
            got.wake_v = m_tdata[1];
            got.wake_after = m_tdata[33:2];
            got.full = m_tdata[34];
            n_results++;
            if (got.locked === 1'b1)
                n_locked++;
            if (got.full === 1'b1)
                n_full++;
            if (pending_results.size() == 0)
            begin
                if (fail_count < 10)
                    $display("result %h with nothing outstanding", m_tdata);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.locked !== want.locked || got.wake_v !== want.wake_v ||
                    got.wake_after !== want.wake_after || got.full !== want.full)
                begin
                    if (fail_count < 10)
                        $display("result %0d: locked %b/%b wake %b/%b after %0d/%0d full %b/%b",
                                 n_results, want.locked, got.locked, want.wake_v, got.wake_v,
                                 want.wake_after, got.wake_after, want.full, got.full);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        logic [3*TICK_W-1:0] cfg;
        logic [REQ_W-1:0] kind;
        logic [ADDR_W-1:0] addr;
        int pool_n;
        int pick;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = REQ_ELAPSED;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        gaps_on = 1'b1;
        fail_count = 0;
        n_items = 0;
        n_results = 0;
        n_locked = 0;
        n_full = 0;
        cur_min_wait = MIN_WAIT_RST;
        cur_max_wait = MAX_WAIT_RST;
        cur_period = PERIOD_RST;
        for (int i = 0; i < ENTRIES; i++)
        begin
            peer_mac[i] = '0;
            peer_valid[i] = 1'b0;
            peer_active[i] = 1'b0;
            peer_level[i] = '0;
            peer_penalty[i] = '0;
            peer_reward[i] = '0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int r = 0; r < DIR_ROWS_N; r++)
            offer_item(DIR_ROWS[r].kind, DIR_ROWS[r].addr, DIR_ROWS[r].ticks,
                       DIR_ROWS[r].typed, DIR_ROWS[r].want);
        s_tvalid <= 1'b0;

        for (int p = 0; p < PHASES; p++)
        begin
            drain_results();
            if (p > 0)
            begin
                if (p == PHASES - 1)
                    cfg = {32'($urandom_range(1, 5000)), 32'($urandom_range(1, 1 << 20)),
                           32'($urandom_range(1, 20000))};
                else
                    cfg = PHASE_CFG[p];
                set_register(REG_MIN_WAIT, cfg[3*TICK_W-1:2*TICK_W]);
                set_register(REG_MAX_WAIT, cfg[2*TICK_W-1:TICK_W]);
                set_register(REG_PERIOD, cfg[TICK_W-1:0]);
            end
            // a long stretch at full rate on both sides
            gaps_on = (p != 2);
            // few peers when chasing the level ceiling, more than fit elsewhere
            pool_n = (p == 1) ? 3 : POOL_N;
            for (int i = 0; i < POOL_N; i++)
                peer_pool[i] = rand_addr();
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    kind = REQ_FAIL;
                else if (pick < 70)
                    kind = REQ_QUERY;
                else if (pick < 95)
                    kind = REQ_ELAPSED;
                else
                    kind = REQ_SPARE;
                addr = ($urandom_range(0, 99) < 85) ? peer_pool[$urandom_range(0, pool_n - 1)]
                                                    : rand_addr();
                offer_item(kind, addr, pick_ticks(), 1'b0, '0);
            end
            s_tvalid <= 1'b0;
        end
        drain_results();
        gaps_on = 1'b0;

        $display("ran %0d requests over %0d register settings, %0d results checked",
                 n_items, PHASES, n_results);
        $display("lockout hits seen: %0d, table-full results seen: %0d, mismatches: %0d",
                 n_locked, n_full, fail_count);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/pbb_pkg.sv
design/pbb_cfg.sv
design/pbb_cell.sv
design/peer_backoff_blacklist_unit.sv
design/pbb_checker.sv
tb/testbench.sv
